// ===== hdl/dfu_frm_pkg.sv =====
// Shared types, constants and CRC helpers for the DFU upload framer.
// No dependencies; every other file in hdl/ uses this package.
package dfu_frm_pkg;

    localparam int C_FILL_W = 13;
    localparam int C_BLK_W  = 16;
    localparam int C_ADDR_W = 3;
    localparam int C_DATA_W = 32;

    localparam logic [C_FILL_W-1:0] C_PKT_RESET = 13'h0800;
    localparam logic [C_FILL_W-1:0] C_PKT_MIN   = 13'd32;
    localparam logic [C_FILL_W-1:0] C_PKT_MAX   = 13'd4096;
    localparam logic [C_FILL_W:0]   C_SFX_LEN   = 14'd16;

    localparam logic [31:0] C_CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] C_CRC_POLY = 32'hEDB8_8320;

    // Suffix word positions: 0..11 fixed bytes, 12..15 CRC bytes
    localparam logic [3:0] C_SFX_FIXED_LAST = 4'd11;
    localparam logic [3:0] C_SFX_LAST       = 4'd15;

    // Register index of the block size register (taken from paddr[2])
    localparam logic C_REG_PKT_SIZE = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [C_BLK_W-1:0] block_number;
        logic               end_of_block;
        logic               end_of_transfer;
        logic               run_end;
    } t_out_word;

    // Reflected CRC-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ C_CRC_POLY) : (v >> 1);
        end
        return v;
    endfunction

    // Fixed suffix bytes FF FF FF FF AC 05 00 01 55 46 44 10
    function automatic logic [7:0] sfx_byte(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3: r = 8'hFF;
            4'd4:    r = 8'hAC;
            4'd5:    r = 8'h05;
            4'd6:    r = 8'h00;
            4'd7:    r = 8'h01;
            4'd8:    r = 8'h55;
            4'd9:    r = 8'h46;
            4'd10:   r = 8'h44;
            4'd11:   r = 8'h10;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dfu_upload_framer_crc32_unit.sv =====
// Top level of the DFU upload framer with suffix CRC-32.
// Depends on dfu_frm_pkg, dfu_frm_cfg, dfu_frm_in_reg and dfu_frm_core.
//
//   Channel   Direction  Handshake                    Word
//   in        sink       i_in_valid / o_in_stall      t_in_word  (data_byte, last_byte)
//   out       source     o_out_valid / i_out_stall    t_out_word (byte, block, flags)
//   cfg       sink       APB psel/penable/pwrite      block size at byte address 0
//
// One image word per cycle flows through while no output stall or suffix burst holds it:
// input register, framing logic, result register; a held word waits in the input register.
// A word flagged last_byte produces 17 output words; the suffix sequencer owns the
// result register for the 16 suffix/CRC words, so the core takes no image word meanwhile.
// Reset is synchronous, active low; it presets CRC, clears fill, block number and valids,
// and sets the block size to 2048. Output stall reaches o_in_stall in the same cycle.
module dfu_upload_framer_crc32_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Image word input
    input  logic                                   i_in_valid,
    input  dfu_frm_pkg::t_in_word                  i_in_data,
    output logic                                   o_in_stall,
    // Framed word output
    output logic                                   o_out_valid,
    output dfu_frm_pkg::t_out_word                 o_out_data,
    input  logic                                   i_out_stall,
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dfu_frm_pkg::C_ADDR_W-1:0]       paddr,
    input  logic [dfu_frm_pkg::C_DATA_W-1:0]       pwdata,
    output logic [dfu_frm_pkg::C_DATA_W-1:0]       prdata,
    output logic                                   pready
);

    logic [dfu_frm_pkg::C_FILL_W-1:0] w_pkt_eff;
    logic                             w_item_valid;
    dfu_frm_pkg::t_in_word            w_item;
    logic                             w_take;

    // Register file: block size, clamped to 32..4096 for the core
    dfu_frm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_pkt_eff (w_pkt_eff)
    );

    // Input register: parts the upstream handshake from the core
    dfu_frm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (w_item_valid),
        .o_data  (w_item),
        .i_take  (w_take)
    );

    // Framing core: CRC, block tracking, suffix burst and result register
    dfu_frm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt_eff    (w_pkt_eff),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_take       (w_take),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ===== hdl/dfu_frm_cfg.sv =====
// APB-style register block holding the block size and deriving its clamped working value.
// Depends on dfu_frm_pkg.
module dfu_frm_cfg (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [dfu_frm_pkg::C_ADDR_W-1:0]       paddr,
    input  logic [dfu_frm_pkg::C_DATA_W-1:0]       pwdata,
    output logic [dfu_frm_pkg::C_DATA_W-1:0]       prdata,
    output logic                                   pready,
    output logic [dfu_frm_pkg::C_FILL_W-1:0]       o_pkt_eff
);

    logic [dfu_frm_pkg::C_FILL_W-1:0] r_pkt_size;
    logic [dfu_frm_pkg::C_FILL_W-1:0] n_pkt_size;
    logic                             w_sel_pkt;

    assign pready    = 1'b1;
    assign w_sel_pkt = (paddr[2] == dfu_frm_pkg::C_REG_PKT_SIZE);

    always_comb begin
        n_pkt_size = r_pkt_size;
        if (psel && penable && pwrite && w_sel_pkt) begin
            n_pkt_size = pwdata[dfu_frm_pkg::C_FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_size <= dfu_frm_pkg::C_PKT_RESET;
        end else begin
            r_pkt_size <= n_pkt_size;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_pkt) begin
            prdata = {{(dfu_frm_pkg::C_DATA_W-dfu_frm_pkg::C_FILL_W){1'b0}}, r_pkt_size};
        end
    end

    // Clamp to the legal block size range
    always_comb begin
        if (r_pkt_size < dfu_frm_pkg::C_PKT_MIN) begin
            o_pkt_eff = dfu_frm_pkg::C_PKT_MIN;
        end else if (r_pkt_size > dfu_frm_pkg::C_PKT_MAX) begin
            o_pkt_eff = dfu_frm_pkg::C_PKT_MAX;
        end else begin
            o_pkt_eff = r_pkt_size;
        end
    end

endmodule

// ===== hdl/dfu_frm_in_reg.sv =====
// Input register stage: holds one accepted word until the core takes it.
// Depends on dfu_frm_pkg.
module dfu_frm_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  dfu_frm_pkg::t_in_word i_data,
    output logic                  o_stall,
    output logic                  o_valid,
    output dfu_frm_pkg::t_in_word o_data,
    input  logic                  i_take
);

    logic                  r_valid;
    logic                  n_valid;
    dfu_frm_pkg::t_in_word r_data;
    logic                  w_load;

    assign o_stall = r_valid && !i_take;
    assign w_load  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== hdl/dfu_frm_core.sv =====
// Framing core: CRC, block fill/number tracking, suffix sequencer, result register.
// Depends on dfu_frm_pkg.
module dfu_frm_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [dfu_frm_pkg::C_FILL_W-1:0]   i_pkt_eff,
    input  logic                               i_item_valid,
    input  dfu_frm_pkg::t_in_word              i_item,
    output logic                               o_take,
    output logic                               o_out_valid,
    output dfu_frm_pkg::t_out_word             o_out_data,
    input  logic                               i_out_stall
);

    logic [31:0]                       r_crc,     n_crc;
    logic [dfu_frm_pkg::C_FILL_W-1:0]  r_fill,    n_fill;
    logic [dfu_frm_pkg::C_BLK_W-1:0]   r_blk,     n_blk;
    logic                              r_sfx_act, n_sfx_act;
    logic [3:0]                        r_sfx_idx, n_sfx_idx;
    logic                              r_ov,      n_ov;
    dfu_frm_pkg::t_out_word            r_out,     n_out;

    logic                              w_out_free;
    logic                              w_fire;
    logic [31:0]                       w_crc_data;
    logic [dfu_frm_pkg::C_FILL_W-1:0]  w_fill1;
    logic [7:0]                        w_sfx_fixed;
    logic [7:0]                        w_crc_part;
    logic                              w_sfx_end;

    assign w_out_free  = !r_ov || !i_out_stall;
    assign o_take      = w_out_free && !r_sfx_act && i_item_valid;
    assign w_fire      = w_out_free && (r_sfx_act || i_item_valid);
    assign w_crc_data  = dfu_frm_pkg::crc_byte(r_crc, i_item.data_byte);
    assign w_fill1     = r_fill + 1'b1;
    assign w_sfx_fixed = dfu_frm_pkg::sfx_byte(r_sfx_idx);
    assign w_sfx_end   = (r_sfx_idx == dfu_frm_pkg::C_SFX_LAST);

    // CRC bytes go out least significant first
    always_comb begin
        case (r_sfx_idx[1:0])
            2'd0:    w_crc_part = r_crc[7:0];
            2'd1:    w_crc_part = r_crc[15:8];
            2'd2:    w_crc_part = r_crc[23:16];
            default: w_crc_part = r_crc[31:24];
        endcase
    end

    always_comb begin
        n_crc     = r_crc;
        n_fill    = r_fill;
        n_blk     = r_blk;
        n_sfx_act = r_sfx_act;
        n_sfx_idx = r_sfx_idx;
        n_out     = r_out;
        n_ov      = r_ov && i_out_stall;
        if (w_fire) begin
            n_ov                  = 1'b1;
            n_out.block_number    = r_blk;
            n_out.end_of_transfer = 1'b0;
            n_out.run_end         = 1'b0;
            n_out.end_of_block    = 1'b0;
            if (r_sfx_act) begin
                n_sfx_idx = r_sfx_idx + 1'b1;
                if (r_sfx_idx <= dfu_frm_pkg::C_SFX_FIXED_LAST) begin
                    n_out.out_byte = w_sfx_fixed;
                    n_crc          = dfu_frm_pkg::crc_byte(r_crc, w_sfx_fixed);
                end else begin
                    n_out.out_byte = w_crc_part;
                end
                if (w_sfx_end) begin
                    n_out.end_of_block    = 1'b1;
                    n_out.end_of_transfer = 1'b1;
                    n_out.run_end         = 1'b1;
                    // Upload done: start over for the next image
                    n_crc     = dfu_frm_pkg::C_CRC_INIT;
                    n_fill    = '0;
                    n_blk     = '0;
                    n_sfx_act = 1'b0;
                end
            end else begin
                n_out.out_byte = i_item.data_byte;
                n_crc          = w_crc_data;
                if (i_item.last_byte) begin
                    n_out.end_of_block = ({1'b0, w_fill1} + dfu_frm_pkg::C_SFX_LEN)
                                         > {1'b0, i_pkt_eff};
                    n_sfx_act = 1'b1;
                    n_sfx_idx = '0;
                end else begin
                    n_out.run_end = 1'b1;
                    if (w_fill1 >= i_pkt_eff) begin
                        n_out.end_of_block = 1'b1;
                        n_fill             = '0;
                        n_blk              = r_blk + 1'b1;
                    end else begin
                        n_fill = w_fill1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= dfu_frm_pkg::C_CRC_INIT;
            r_fill    <= '0;
            r_blk     <= '0;
            r_sfx_act <= 1'b0;
            r_sfx_idx <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_crc     <= n_crc;
            r_fill    <= n_fill;
            r_blk     <= n_blk;
            r_sfx_act <= n_sfx_act;
            r_sfx_idx <= n_sfx_idx;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // A final image byte must hand over to the suffix sequencer at word zero
    a_last_starts_sfx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_item.last_byte) |=> (r_sfx_act && r_sfx_idx == 4'd0))
        else $error("suffix sequencer did not start after final byte");

    // The final suffix word must leave the run state cleared
    a_sfx_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_sfx_act && w_sfx_end) |=>
        (!r_sfx_act && r_crc == dfu_frm_pkg::C_CRC_INIT && r_blk == '0 && r_fill == '0))
        else $error("run state not cleared after final CRC byte");

    // End of transfer only ever marks the closing word of a block and run
    a_eot_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.end_of_transfer) |-> (r_out.end_of_block && r_out.run_end))
        else $error("end of transfer without end of block and run end");

    // Block number stays put across the whole suffix burst
    a_blk_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sfx_act && !(w_fire && w_sfx_end)) |=> $stable(r_blk))
        else $error("block number changed during suffix");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dfu_upload_framer_crc32_unit: image words in, framed words out.
// Needs dfu_frm_pkg and the framer RTL; a built-in predictor supplies the expected words.
module tb_top;

    // Watchdog limit, in cycles with no word moving on either channel and no bus access.
    localparam int WATCHDOG_LIMIT = 2000;
    // Tail after the last expected word, to catch stray output.
    localparam int TAIL_CYCLES = 20;
    // Suffix fixed bytes, first byte in the top octet.
    localparam logic [95:0] SUFFIX_FIXED = 96'hFFFF_FFFF_AC05_0001_5546_4410;
    localparam int SUFFIX_FIXED_LEN = 12;
    localparam int SUFFIX_TOTAL_LEN = 16;
    localparam logic [dfu_frm_pkg::C_ADDR_W-1:0] PKT_SIZE_ADDR =
        {dfu_frm_pkg::C_REG_PKT_SIZE, 2'b00};

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    dfu_frm_pkg::t_in_word                i_in_data = '0;
    logic                                 o_in_stall;
    logic                                 o_out_valid;
    dfu_frm_pkg::t_out_word               o_out_data;
    logic                                 i_out_stall = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [dfu_frm_pkg::C_ADDR_W-1:0]     paddr = '0;
    logic [dfu_frm_pkg::C_DATA_W-1:0]     pwdata = '0;
    logic [dfu_frm_pkg::C_DATA_W-1:0]     prdata;
    logic                                 pready;

    dfu_upload_framer_crc32_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle rates, in percent, for the sending and the receiving side.
    int unsigned in_gap_pct = 0;
    int unsigned out_stall_pct = 0;

    int unsigned err_count = 0;
    int unsigned words_in = 0;
    int unsigned words_out = 0;
    int unsigned sizes_set = 0;
    int unsigned idle_cycles = 0;

    // Predictor state: our own copy of the register and the framing state.
    logic [dfu_frm_pkg::C_FILL_W-1:0] pkt_size_shadow = dfu_frm_pkg::C_PKT_RESET;
    logic [31:0]                      crc_run = dfu_frm_pkg::C_CRC_INIT;
    logic [dfu_frm_pkg::C_FILL_W-1:0] fill_run = '0;
    logic [dfu_frm_pkg::C_BLK_W-1:0]  blk_run = '0;

    // Framed words still owed by the block, oldest first.
    dfu_frm_pkg::t_out_word frames_due[$];

    function automatic void note_error(input string what);
        err_count++;
        if (err_count <= 10) begin
            $display("tb_top: %s", what);
        end
    endfunction

    // Reflected CRC-32, one byte, LSB first; the poly is folded in by mask.
    function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        repeat (8) begin
            r = (r >> 1) ^ (dfu_frm_pkg::C_CRC_POLY & {32{r[0]}});
        end
        return r;
    endfunction

    // Effective block size: the register clamped to the legal span.
    function automatic int unsigned clamp_block_size(
        input logic [dfu_frm_pkg::C_FILL_W-1:0] sz);
        if (sz < dfu_frm_pkg::C_PKT_MIN) begin
            return dfu_frm_pkg::C_PKT_MIN;
        end
        if (sz > dfu_frm_pkg::C_PKT_MAX) begin
            return dfu_frm_pkg::C_PKT_MAX;
        end
        return sz;
    endfunction

    // Work out the framed words for one accepted image word and queue them.
    // A last word drags the 12 fixed suffix bytes and 4 CRC bytes behind it,
    // all tagged with the block number of the last image byte.
    function automatic void frame_image_word(input dfu_frm_pkg::t_in_word w);
        int unsigned            eff;
        int unsigned            fill_next;
        int                     i;
        logic [31:0]            c;
        dfu_frm_pkg::t_out_word o;
        eff = clamp_block_size(pkt_size_shadow);
        crc_run = crc32_shift(crc_run, w.data_byte);
        fill_next = fill_run + 1;
        o.out_byte = w.data_byte;
        o.block_number = blk_run;
        o.end_of_transfer = 1'b0;
        if (!w.last_byte) begin
            // Plain pass-through; close the block once the fill reaches its size.
            o.end_of_block = (fill_next >= eff);
            o.run_end = 1'b1;
            frames_due.push_back(o);
            if (o.end_of_block) begin
                fill_run = '0;
                blk_run = blk_run + 1'b1;
            end else begin
                fill_run = fill_next[dfu_frm_pkg::C_FILL_W-1:0];
            end
        end else begin
            // Close the block early when the suffix will not fit behind this byte.
            o.end_of_block = (fill_next + SUFFIX_TOTAL_LEN > eff);
            o.run_end = 1'b0;
            frames_due.push_back(o);
            c = crc_run;
            o.end_of_block = 1'b0;
            for (i = 0; i < SUFFIX_FIXED_LEN; i++) begin
                o.out_byte = SUFFIX_FIXED[95 - 8 * i -: 8];
                c = crc32_shift(c, o.out_byte);
                frames_due.push_back(o);
            end
            for (i = 0; i < 4; i++) begin
                o.out_byte = c[8 * i +: 8];
                o.end_of_block = (i == 3);
                o.end_of_transfer = (i == 3);
                o.run_end = (i == 3);
                frames_due.push_back(o);
            end
            // Upload done: start the next one fresh, keep the register.
            crc_run = dfu_frm_pkg::C_CRC_INIT;
            fill_run = '0;
            blk_run = '0;
        end
    endfunction

    // Receiver: stall at the current rate, redrawn each cycle.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Check every accepted framed word against the oldest one owed.
    always @(posedge i_clk) begin
        dfu_frm_pkg::t_out_word want;
        string                  bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (frames_due.size() == 0) begin
                note_error($sformatf("unexpected word: byte %02h blk %0d eob %b eot %b re %b",
                    o_out_data.out_byte, o_out_data.block_number, o_out_data.end_of_block,
                    o_out_data.end_of_transfer, o_out_data.run_end));
            end else begin
                want = frames_due.pop_front();
                bad = "";
                if (o_out_data.out_byte !== want.out_byte) bad = {bad, " out_byte"};
                if (o_out_data.block_number !== want.block_number) bad = {bad, " block_number"};
                if (o_out_data.end_of_block !== want.end_of_block) bad = {bad, " end_of_block"};
                if (o_out_data.end_of_transfer !== want.end_of_transfer) begin
                    bad = {bad, " end_of_transfer"};
                end
                if (o_out_data.run_end !== want.run_end) bad = {bad, " run_end"};
                if (bad != "") begin
                    note_error($sformatf({"word %0d mismatch on%s: expected byte %02h blk %0d ",
                        "eob %b eot %b re %b, got byte %02h blk %0d eob %b eot %b re %b"},
                        words_out, bad, want.out_byte, want.block_number, want.end_of_block,
                        want.end_of_transfer, want.run_end, o_out_data.out_byte,
                        o_out_data.block_number, o_out_data.end_of_block,
                        o_out_data.end_of_transfer, o_out_data.run_end));
                end
            end
        end
    end

    // Watchdog: give up when no word or bus access moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles < WATCHDOG_LIMIT) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            $display("tb_top: timeout, nothing moved for %0d cycles, %0d words still owed",
                WATCHDOG_LIMIT, frames_due.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Offer one image word, idling first at the sender's rate; return once accepted.
    task automatic send_image_word(input logic [7:0] b, input logic last);
        dfu_frm_pkg::t_in_word w;
        w.data_byte = b;
        w.last_byte = last;
        while ($urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_stall);
        frame_image_word(w);
        words_in++;
    endtask

    // Drop valid and hold until every owed word has come out.
    task automatic wait_frames_out();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready. Leaves psel high;
    // the caller releases the bus.
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PKT_SIZE_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    // Read the block size register back, compare, and release the bus.
    task automatic check_xfer_size(input logic [dfu_frm_pkg::C_FILL_W-1:0] want);
        logic [31:0] rd;
        apb_access(1'b0, 32'h0, rd);
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(32 - dfu_frm_pkg::C_FILL_W){1'b0}}, want}) begin
            note_error($sformatf("block size reads %08h, expected %08h", rd, want));
        end
    endtask

    // Program the block size (junk in the unused upper bits), then read it back.
    task automatic set_xfer_size(input logic [dfu_frm_pkg::C_FILL_W-1:0] sz);
        logic [31:0] wd;
        logic [31:0] rd;
        wd = $urandom;
        wd[dfu_frm_pkg::C_FILL_W-1:0] = sz;
        apb_access(1'b1, wd, rd);
        pkt_size_shadow = sz;
        sizes_set++;
        check_xfer_size(sz);
    endtask

    // Reset value of the register and short uploads at the default block size,
    // all-zero and all-one bytes, and a single-byte upload.
    task automatic test_defaults();
        check_xfer_size(dfu_frm_pkg::C_PKT_RESET);
        send_image_word(8'h00, 1'b0);
        send_image_word(8'hFF, 1'b0);
        send_image_word(8'h5A, 1'b1);
        send_image_word(8'hA5, 1'b1);
    endtask

    // Block sizes below the lower end, and at and beyond the upper end, of the legal span.
    task automatic test_size_extremes();
        int unsigned k;
        wait_frames_out();
        // Zero clamps up to 32: a 16-byte upload plus suffix fills it exactly.
        set_xfer_size(13'd0);
        for (k = 0; k < 16; k++) begin
            send_image_word((k == 0) ? 8'h80 : 8'($urandom_range(255)), k == 15);
        end
        wait_frames_out();
        set_xfer_size(13'd31);
        send_image_word(8'h7F, 1'b1);
        wait_frames_out();
        set_xfer_size(13'h1FFF);
        send_image_word(8'h01, 1'b1);
        wait_frames_out();
        set_xfer_size(13'd4097);
        send_image_word(8'hFE, 1'b1);
        wait_frames_out();
        set_xfer_size(13'd4096);
        send_image_word(8'h10, 1'b1);
    endtask

    // Shrink the block size while a block is part full: the next byte closes it.
    task automatic test_size_lowered();
        int unsigned k;
        wait_frames_out();
        set_xfer_size(13'd64);
        for (k = 0; k < 40; k++) begin
            send_image_word(8'($urandom_range(255)), 1'b0);
        end
        wait_frames_out();
        set_xfer_size(13'd32);
        send_image_word(8'($urandom_range(255)), 1'b0);
        for (k = 0; k < 20; k++) begin
            send_image_word(8'($urandom_range(255)), k == 19);
        end
    endtask

    // Random uploads. Lengths lean toward the suffix-fit boundaries; sizes are
    // mostly small, now and then the largest; a resize sometimes lands mid-upload.
    task automatic test_random_uploads(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned eff;
        int unsigned len;
        int unsigned j;
        logic [dfu_frm_pkg::C_FILL_W-1:0] sz;
        stop_at = words_in + n_words;
        while (words_in < stop_at) begin
            wait_frames_out();
            if ($urandom_range(9) == 0) begin
                sz = $urandom_range(1) ? 13'd4096 : 13'($urandom_range(8191, 4097));
                len = $urandom_range(20, 1);
            end else begin
                sz = ($urandom_range(7) == 0) ? 13'($urandom_range(31))
                                             : 13'($urandom_range(64, 32));
                eff = clamp_block_size(sz);
                case ($urandom_range(4))
                    0: len = eff - SUFFIX_TOTAL_LEN;
                    1: len = eff - SUFFIX_TOTAL_LEN + 1;
                    2: len = eff;
                    3: len = 2 * eff - SUFFIX_TOTAL_LEN;
                    default: len = $urandom_range(2 * eff, 1);
                endcase
            end
            set_xfer_size(sz);
            for (j = 0; j < len; j++) begin
                if (j != 0 && $urandom_range(24) == 0) begin
                    wait_frames_out();
                    set_xfer_size(13'($urandom_range(64, 32)));
                end
                send_image_word(8'($urandom_range(255)), j == len - 1);
            end
        end
    endtask

    initial begin
        // Hold reset low, then release it at a clock edge.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles lightly, receiver stalls heavily.
        in_gap_pct = 23;
        out_stall_pct = 71;
        test_defaults();
        test_size_extremes();
        test_size_lowered();
        test_random_uploads(30);

        // Swap the pressure: sender idles heavily, receiver stalls lightly.
        in_gap_pct = 71;
        out_stall_pct = 23;
        test_random_uploads(30);

        // Full rate on both sides.
        in_gap_pct = 0;
        out_stall_pct = 0;
        test_random_uploads(30);

        // Drain, then watch a short tail for stray words.
        wait_frames_out();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d image words sent, %0d framed words checked, %0d size writes",
            words_in, words_out, sizes_set);
        $display("tb_top: covered size clamps, suffix split and mid-block resize");
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches in total", err_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dfu_frm_pkg.sv
hdl/dfu_frm_cfg.sv
hdl/dfu_frm_in_reg.sv
hdl/dfu_frm_core.sv
hdl/dfu_upload_framer_crc32_unit.sv
sim/tb_top.sv
